// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/bae_pkg.sv =====
// Shared widths and controller/datapath interface types for the encoder.
// No dependencies.
`timescale 1ns / 1ps

package bae_pkg;

  localparam int PROB_W  = 12;
  localparam int BOUND_W = 32;
  localparam int BYTE_W  = 8;
  localparam int PROD_W  = BOUND_W + PROB_W;

  typedef struct packed {
    logic load_in;
    logic load_prod;
    logic update;
    logic shift_emit;
    logic flush_emit;
    logic flush_last;
    logic restart;
  } dp_cmd_t;

  typedef struct packed {
    logic top_match;
    logic out_free;
    logic fin;
  } dp_sts_t;

endpackage

// ===== hw/rtl/bae_ctrl.sv =====
// Sequencing state machine for the encoder.
// Depends on bae_pkg; drives bae_dpath through dp_cmd_t.
`timescale 1ns / 1ps

module bae_ctrl import bae_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_RENORM,
    S_FLUSH
  } state_t;

  state_t     state;
  logic [1:0] flush_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      flush_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_RENORM;
        end
        S_RENORM: begin
          if (!sts.top_match) begin
            flush_cnt <= '0;
            state     <= sts.fin ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (sts.out_free) begin
            flush_cnt <= flush_cnt + 2'd1;
            if (flush_cnt == 2'd3) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
      end
      S_MUL: begin
        cmd.load_prod = 1'b1;
      end
      S_UPD: begin
        cmd.update = 1'b1;
      end
      S_RENORM: begin
        cmd.shift_emit = sts.top_match && sts.out_free;
      end
      S_FLUSH: begin
        cmd.flush_emit = sts.out_free;
        cmd.flush_last = (flush_cnt == 2'd3);
        cmd.restart    = sts.out_free && (flush_cnt == 2'd3);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bae_dpath.sv =====
// Bound registers, split multiplier and output register of the encoder.
// Depends on bae_pkg; commanded by bae_ctrl.
`timescale 1ns / 1ps

module bae_dpath import bae_pkg::*; #(
  parameter int PROB_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              bit_value,
  input  logic [PROB_W-1:0] prob_one,
  input  logic              final_item,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] code_byte,
  output logic              stream_end
);

  localparam int PMAX_INT = (PROB_BITS >= PROB_W) ? ((1 << PROB_W) - 1)
                                                  : ((1 << PROB_BITS) - 1);
  localparam logic [PROB_W-1:0] PROB_MAX = PROB_W'(PMAX_INT);

  logic [BOUND_W-1:0] low;
  logic [BOUND_W-1:0] high;
  logic [BOUND_W-1:0] span;
  logic [PROB_W-1:0]  prob;
  logic               bit_r;
  logic               fin;
  logic [PROD_W-1:0]  prod;

  logic [PROB_W-1:0]  prob_c;
  logic [PROD_W-1:0]  prod_sh;
  logic [BOUND_W-1:0] mid;
  logic               emit;

  always_comb begin
    if (prob_one == '0) begin
      prob_c = PROB_W'(1);
    end else if (prob_one > PROB_MAX) begin
      prob_c = PROB_MAX;
    end else begin
      prob_c = prob_one;
    end
  end

  assign prod_sh = prod >> PROB_BITS;
  assign mid     = low + prod_sh[BOUND_W-1:0];
  assign emit    = cmd.shift_emit || cmd.flush_emit;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bit_r <= bit_value;
      fin   <= final_item;
      prob  <= prob_c;
      span  <= high - low;
    end
    if (cmd.load_prod) begin
      prod <= {{PROB_W{1'b0}}, span} * {{BOUND_W{1'b0}}, prob};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= '0;
      high <= '1;
    end else if (cmd.restart) begin
      low  <= '0;
      high <= '1;
    end else if (cmd.update) begin
      if (bit_r) begin
        high <= mid;
      end else begin
        low <= mid + BOUND_W'(1);
      end
    end else if (cmd.shift_emit) begin
      low  <= {low[BOUND_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
      high <= {high[BOUND_W-BYTE_W-1:0], {BYTE_W{1'b1}}};
    end else if (cmd.flush_emit) begin
      low  <= {low[BOUND_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      code_byte  <= cmd.shift_emit ? high[BOUND_W-1 -: BYTE_W] : low[BOUND_W-1 -: BYTE_W];
      stream_end <= cmd.flush_last;
    end
  end

  assign sts.top_match = (low[BOUND_W-1 -: BYTE_W] == high[BOUND_W-1 -: BYTE_W]);
  assign sts.out_free  = !out_valid || !out_stall;
  assign sts.fin       = fin;

endmodule

// ===== hw/rtl/binary_arith_encoder.sv =====
// Top level of the carry-less binary arithmetic encoder.
// Depends on bae_pkg, bae_ctrl and bae_dpath.
//
// Input channel: in_valid / in_stall carry one symbol (bit_value), its
// probability of a one (prob_one, clamped to 1..2^min(PROB_BITS,PROB_W)-1) and
// final_item, which closes the stream after this symbol.
// Output channel: out_valid / out_stall carry code_byte; stream_end marks the
// fourth and last flushed byte of a stream.
// Sequence: an item is taken in S_IDLE, the span product is registered in
// S_MUL and the bounds update in S_UPD; S_RENORM then checks the top bytes
// and emits one renormalisation byte each time they match and the output
// register is free. A final item then passes through S_FLUSH, which emits
// four flush bytes. Each item makes a single multiplier pass, and the output
// register takes one byte per cycle while the receiver does not stall.
// in_stall is high outside S_IDLE, which follows loading the item's last byte
// into the output register; the next item is taken while it waits downstream.
// A stalled receiver holds the output register and pauses byte emission.
// Reset sets the bounds to 0 and all ones and empties the output register;
// after a flush the bounds return to the same values for a fresh stream.
`timescale 1ns / 1ps

module binary_arith_encoder import bae_pkg::*; #(
  parameter int PROB_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              bit_value,
  input  logic [PROB_W-1:0] prob_one,
  input  logic              final_item,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] code_byte,
  output logic              stream_end
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bae_dpath #(
    .PROB_BITS (PROB_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .bit_value  (bit_value),
    .prob_one   (prob_one),
    .final_item (final_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_byte  (code_byte),
    .stream_end (stream_end)
  );

endmodule

// ===== hw/rtl/bae_checker.sv =====
// Port-level checker for binary_arith_encoder, attached by bind.
// Depends on assert_macros.svh and bae_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bae_checker import bae_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] code_byte,
  input logic              stream_end
);

  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(code_byte) && $stable(stream_end))
  `CHK_IMPLY(a_idle_after_reset, clk, rst, $past(rst), !out_valid && !in_stall)
  `CHK_IMPLY(a_busy_after_accept, clk, rst, $past(in_valid && !in_stall, 2) && !$past(rst) && !$past(rst, 2), in_stall)

endmodule

bind binary_arith_encoder bae_checker u_bae_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .code_byte  (code_byte),
  .stream_end (stream_end)
);
